@@ rtl/core/rled_pkg.sv @@
// Shared types and constants for the LED effect generator.
// Holds the opcode and mode codes, register indexes, controller-datapath
// command and status structs. No dependencies.
`default_nettype none

package rled_pkg;

  // Field widths
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned CountW    = 6;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_KEY   = 2'd1,
    OP_PIXEL = 2'd2,
    OP_NONE  = 2'd3
  } rled_op_e;

  // Effect modes
  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_BREATH  = 2'd1,
    MODE_REACT   = 2'd2,
    MODE_RAINBOW = 2'd3
  } rled_mode_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMode     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCount    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInterval = 2'd2;

  // Register reset values
  localparam rled_mode_e           ModeRst     = MODE_RAINBOW;
  localparam logic [CountW-1:0]    CountRst    = 6'd32;
  localparam logic [IntervalW-1:0] IntervalRst = 16'd20;

  // Effect constants
  localparam logic [ColorW-1:0] HueFixed  = 8'd128;
  localparam logic [ColorW-1:0] SatFull   = 8'd255;
  localparam logic [ColorW-1:0] ChanMax   = 8'd255;
  localparam logic [ColorW-1:0] ValDim    = 8'd60;
  localparam logic [ColorW-1:0] ReactLoad = 8'd150;
  localparam logic [ColorW-1:0] SectorW   = 8'd43;
  localparam logic [ColorW-1:0] FracMul   = 8'd6;

  // Breathing period arithmetic: remainder mod 2000, quotient by 10
  localparam int unsigned       PeriodW    = 11;
  localparam logic [10:0]       BreathHalf = 11'd1000;
  localparam logic [ColorW-1:0] BreathTop  = 8'd200;
  localparam logic [12:0]       Recip10    = 13'd6554;
  localparam logic [3:0]        StepDiv5   = 4'd5;

  // Remainder unit: (time >> 4) mod 125 by reciprocal, then the low nibble
  // appended; ceil(2^35 / 125), exact for dividends below 2^28
  localparam int unsigned DigitW   = 4;
  localparam logic [28:0] Recip125 = 29'd274877907;
  localparam logic [6:0]  Div125   = 7'd125;
  localparam int unsigned ModSteps = 2;
  localparam int unsigned ModCntW  = 1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic mod_step;
    logic quo_step;
    logic rem_step;
    logic apply;
    logic hsv1;
    logic hsv2;
    logic hsv3;
    logic res_load;
  } rled_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    rled_op_e in_op;
    logic     in_needs_mod;
    rled_op_e op;
    logic     mod_last;
  } rled_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/rled_in_if.sv @@
// Input channel of the LED effect generator: valid/ready plus item fields.
// Depends on rled_pkg.
`default_nettype none

interface rled_in_if;
  import rled_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [TimeW-1:0]  time_ms;
  logic [IdxW-1:0]   led_index;
  logic              strip_busy;

  modport source (output valid, command, time_ms, led_index, strip_busy, input ready);
  modport sink   (input valid, command, time_ms, led_index, strip_busy, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rled_out_if.sv @@
// Result channel of the LED effect generator: valid/ready plus colour fields.
// Depends on rled_pkg.
`default_nettype none

interface rled_out_if;
  import rled_pkg::*;

  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;
  logic              frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rled_ctrl.sv @@
// Sequencing FSM of the LED effect generator: handshakes and stage strobes.
// Depends on rled_pkg; drives rled_dp through rled_cmd_t.
`default_nettype none

module rled_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rled_pkg::rled_stat_t stat_i,
  output rled_pkg::rled_cmd_t  cmd_o
);
  import rled_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MOD   = 9'b000000010,
    ST_QUO   = 9'b000000100,
    ST_REM   = 9'b000001000,
    ST_APPLY = 9'b000010000,
    ST_HSV1  = 9'b000100000,
    ST_HSV2  = 9'b001000000,
    ST_HSV3  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } rled_state_e;

  rled_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Next state and strobes
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (stat_i.in_needs_mod) begin
            state_d = ST_MOD;
          end else begin
            unique case (stat_i.in_op)
              OP_KEY:   state_d = ST_APPLY;
              OP_PIXEL: state_d = ST_HSV1;
              default:  state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) state_d = ST_QUO;
      end
      ST_QUO: begin
        cmd_o.quo_step = 1'b1;
        state_d        = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem_step = 1'b1;
        state_d        = (stat_i.op == OP_TICK) ? ST_APPLY : ST_HSV1;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_DONE;
      end
      ST_HSV1: begin
        cmd_o.hsv1 = 1'b1;
        state_d    = ST_HSV2;
      end
      ST_HSV2: begin
        cmd_o.hsv2 = 1'b1;
        state_d    = ST_HSV3;
      end
      ST_HSV3: begin
        cmd_o.hsv3 = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register occupancy
  assign out_valid_d = cmd_o.res_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/rled_dp.sv @@
// Datapath of the LED effect generator: config registers, effect state,
// mod-2000 unit, breathing value, three-stage HSV-to-RGB, result reg.
// Depends on rled_pkg; strobed by rled_ctrl.
`default_nettype none

module rled_dp #(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rled_pkg::rled_cmd_t             cmd_i,
  output rled_pkg::rled_stat_t            stat_o,
  input  logic [1:0]                      command_i,
  input  logic [rled_pkg::TimeW-1:0]      time_ms_i,
  input  logic [rled_pkg::IdxW-1:0]       led_index_i,
  input  logic                            strip_busy_i,
  input  logic                            cfg_we_i,
  input  logic [rled_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rled_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic [rled_pkg::ColorW-1:0]     red_o,
  output logic [rled_pkg::ColorW-1:0]     green_o,
  output logic [rled_pkg::ColorW-1:0]     blue_o,
  output logic                            frame_start_o
);
  import rled_pkg::*;

  localparam int unsigned HueStepInt = 256 / MAX_LEDS;
  localparam logic [8:0]  HueStep    = 9'(HueStepInt);

  // Configuration and effect state
  rled_mode_e           mode_q;
  logic [CountW-1:0]    count_q;
  logic [IntervalW-1:0] interval_q;
  logic [TimeW-1:0]     last_step_q, last_frame_q;
  logic [ColorW-1:0]    hue_q, react_q;

  // Captured item
  rled_op_e             op_q;
  logic [TimeW-1:0]     time_q;
  logic [IdxW-1:0]      idx_q;
  logic                 busy_q;

  // Remainder unit and breathing value
  logic [21:0]          q125_q;
  logic [PeriodW-1:0]   p_q;
  logic [ModCntW-1:0]   cnt_q;
  logic [ColorW-1:0]    q10_q, bv_q;
  logic [3:0]           rem10_q;
  logic                 fs_q;

  // HSV pipeline
  logic [2:0]           sec_q;
  logic [ColorW-1:0]    frac_q, val_q, tf_q, tr_q, lo_q, fall_q, rise_q;

  // Result register
  logic [ColorW-1:0]    red_q, green_q, blue_q;
  logic                 frame_q;

  // Incoming beat decode for the controller
  rled_op_e in_op;
  logic     in_lit, lit;

  assign in_op  = rled_op_e'(command_i);
  assign in_lit = ({1'b0, led_index_i} < count_q);
  assign lit    = ({1'b0, idx_q} < count_q);

  always_comb begin
    stat_o.in_op        = in_op;
    stat_o.in_needs_mod = (in_op == OP_TICK) ||
                          ((in_op == OP_PIXEL) && in_lit && (mode_q == MODE_BREATH));
    stat_o.op           = op_q;
    stat_o.mod_last     = (cnt_q == ModCntW'(ModSteps - 1));
  end

  // time mod 2000 = ((time >> 4) mod 125) * 16 + time[3:0]
  // first step: quotient by 125 via reciprocal; second step: remainder
  logic [56:0]        t4_prod;
  logic [27:0]        q125_x, rem125_full;
  logic [PeriodW-1:0] p_nxt;

  assign t4_prod     = 57'(time_q[TimeW-1:DigitW]) * 57'(Recip125);
  assign q125_x      = 28'(q125_q) * 28'(Div125);
  assign rem125_full = time_q[TimeW-1:DigitW] - q125_x;
  assign p_nxt       = {rem125_full[6:0], time_q[DigitW-1:0]};

  // p / 10 by reciprocal, exact for p below 2048
  logic [23:0] q_prod;
  assign q_prod = 24'(p_q) * 24'(Recip10);

  // Remainder by 10 and breathing triangle value
  logic [PeriodW-1:0] ten_q10;
  logic [PeriodW-1:0] rem_full;
  logic [3:0]         rem10_c;
  logic [ColorW-1:0]  bv_c;

  always_comb begin
    ten_q10  = {q10_q, 3'b000} + {2'b00, q10_q, 1'b0};
    rem_full = p_q - ten_q10;
    rem10_c  = rem_full[3:0];
    if (p_q < BreathHalf) begin
      bv_c = q10_q;
    end else begin
      bv_c = BreathTop - q10_q - {7'd0, (rem10_c != 4'd0)};
    end
  end

  // Tick bookkeeping
  logic [TimeW-1:0] frame_diff;
  logic             frame_due, step_new, hue_tick, react_tick;

  assign frame_diff = time_q - last_frame_q;
  assign frame_due  = (frame_diff >= {16'd0, interval_q});
  assign step_new   = (time_q != last_step_q);
  assign hue_tick   = (rem10_q == 4'd0);
  assign react_tick = (rem10_q == 4'd0) || (rem10_q == StepDiv5);

  // Hue and value selection, sector split
  logic [13:0]       hue_prod;
  logic [ColorW-1:0] h_c, v_c, base_c, off_c, frac_c;
  logic [2:0]        sec_c;

  assign hue_prod = 14'(idx_q) * 14'(HueStep);

  always_comb begin
    unique case (mode_q)
      MODE_STATIC:  begin h_c = HueFixed; v_c = ValDim;  end
      MODE_BREATH:  begin h_c = HueFixed; v_c = bv_q;    end
      MODE_REACT:   begin h_c = HueFixed; v_c = react_q; end
      MODE_RAINBOW: begin h_c = hue_q + hue_prod[ColorW-1:0]; v_c = ValDim; end
      default:      begin h_c = HueFixed; v_c = ValDim;  end
    endcase
    priority if (h_c >= 8'(SectorW * 5)) begin
      sec_c = 3'd5;
    end else if (h_c >= 8'(SectorW * 4)) begin
      sec_c = 3'd4;
    end else if (h_c >= 8'(SectorW * 3)) begin
      sec_c = 3'd3;
    end else if (h_c >= 8'(SectorW * 2)) begin
      sec_c = 3'd2;
    end else if (h_c >= SectorW) begin
      sec_c = 3'd1;
    end else begin
      sec_c = 3'd0;
    end
    base_c = 8'(SectorW * sec_c);
    off_c  = h_c - base_c;
    frac_c = 8'(off_c * FracMul);
  end

  // Saturation and channel products
  logic [15:0] tf_prod, tr_prod, lo_prod, fall_prod, rise_prod;

  assign tf_prod   = 16'(SatFull) * 16'(frac_q);
  assign tr_prod   = 16'(SatFull) * 16'(ChanMax - frac_q);
  assign lo_prod   = 16'(val_q) * 16'(ChanMax - SatFull);
  assign fall_prod = 16'(val_q) * 16'(ChanMax - tf_q);
  assign rise_prod = 16'(val_q) * 16'(ChanMax - tr_q);

  // Colour selection by sector
  logic [ColorW-1:0] r_c, g_c, b_c;

  always_comb begin
    unique case (sec_q)
      3'd0:    begin r_c = val_q;  g_c = rise_q; b_c = lo_q;   end
      3'd1:    begin r_c = fall_q; g_c = val_q;  b_c = lo_q;   end
      3'd2:    begin r_c = lo_q;   g_c = val_q;  b_c = rise_q; end
      3'd3:    begin r_c = lo_q;   g_c = fall_q; b_c = val_q;  end
      3'd4:    begin r_c = rise_q; g_c = lo_q;   b_c = val_q;  end
      default: begin r_c = val_q;  g_c = lo_q;   b_c = fall_q; end
    endcase
  end

  // Configuration and effect state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeRst;
      count_q      <= CountRst;
      interval_q   <= IntervalRst;
      last_step_q  <= '0;
      last_frame_q <= '0;
      hue_q        <= '0;
      react_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        priority if (cfg_idx_i == RegMode) begin
          mode_q <= rled_mode_e'(cfg_data_i[1:0]);
        end else if (cfg_idx_i == RegCount) begin
          count_q <= cfg_data_i[CountW-1:0];
        end else if (cfg_idx_i == RegInterval) begin
          interval_q <= cfg_data_i;
        end else begin
          mode_q <= mode_q;
        end
      end
      if (cmd_i.apply && (op_q == OP_TICK)) begin
        if (step_new) begin
          last_step_q <= time_q;
          if (hue_tick) hue_q <= hue_q + 8'd1;
          if (react_tick && (react_q != '0)) react_q <= react_q - 8'd1;
        end
        if (frame_due) last_frame_q <= time_q;
      end else if (cmd_i.apply && (op_q == OP_KEY)) begin
        react_q <= ReactLoad;
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= in_op;
      time_q <= time_ms_i;
      idx_q  <= led_index_i;
      busy_q <= strip_busy_i;
      p_q    <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.mod_step) begin
      if (cnt_q == '0) begin
        q125_q <= t4_prod[56:35];
      end else begin
        p_q <= p_nxt;
      end
      cnt_q <= cnt_q + ModCntW'(1);
    end
    if (cmd_i.quo_step) q10_q <= q_prod[23:16];
    if (cmd_i.rem_step) begin
      rem10_q <= rem10_c;
      bv_q    <= bv_c;
    end
    if (cmd_i.apply) fs_q <= frame_due & ~busy_q;
    if (cmd_i.hsv1) begin
      sec_q  <= sec_c;
      frac_q <= frac_c;
      val_q  <= v_c;
    end
    if (cmd_i.hsv2) begin
      tf_q <= tf_prod[15:8];
      tr_q <= tr_prod[15:8];
      lo_q <= lo_prod[15:8];
    end
    if (cmd_i.hsv3) begin
      fall_q <= fall_prod[15:8];
      rise_q <= rise_prod[15:8];
    end
    if (cmd_i.res_load) begin
      if ((op_q == OP_PIXEL) && lit) begin
        red_q   <= r_c;
        green_q <= g_c;
        blue_q  <= b_c;
      end else begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
      end
      frame_q <= (op_q == OP_TICK) ? fs_q : 1'b0;
    end
  end

  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign frame_start_o = frame_q;

endmodule

`default_nettype wire

@@ rtl/core/rgb_led_effect_generator_top.sv @@
// Top level of the LED effect generator: joins rled_ctrl and rled_dp to the
// item and result channels and the config write port.
// Depends on rled_pkg, rled_in_if, rled_out_if, rled_ctrl, rled_dp.
//
//   port      | dir  | carries
//   ----------+------+-----------------------------------------------------
//   item_i    | in   | command, time_ms, led_index, strip_busy (valid/ready)
//   result_o  | out  | red, green, blue, frame_start (valid/ready)
//   cfg_*     | in   | write enable, register index, 16-bit data
//
// One item at a time. A keypress goes to the apply step, an unknown command
// straight to the final step, and a pixel through the HSV steps.
// Ticks and lit breathing pixels first pass the mod-2000 unit (reciprocal
// quotient, then remainder) and the divide by 10; a tick then goes to apply.
// Reset is asynchronous and needs no clearing pass.
// A new beat is taken while the previous result still waits in the output
// register; a stalled result holds the block in its final step.
`default_nettype none

module rgb_led_effect_generator_top #(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rled_in_if.sink                       item_i,
  rled_out_if.source                    result_o,
  input  logic                          cfg_we_i,
  input  logic [rled_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rled_pkg::CfgDataW-1:0] cfg_data_i
);
  import rled_pkg::*;

  rled_cmd_t  cmd;
  rled_stat_t stat;

  // Sequencer
  rled_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  rled_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .command_i     (item_i.command),
    .time_ms_i     (item_i.time_ms),
    .led_index_i   (item_i.led_index),
    .strip_busy_i  (item_i.strip_busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .red_o         (result_o.red),
    .green_o       (result_o.green),
    .blue_o        (result_o.blue),
    .frame_start_o (result_o.frame_start)
  );

endmodule

`default_nettype wire

@@ rtl/core/rled_checker.sv @@
// Port-level checks for the LED effect generator, bound to the top level.
// Depends on rled_pkg widths only.
`default_nettype none

module rled_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [rled_pkg::ColorW-1:0]  red_i,
  input logic [rled_pkg::ColorW-1:0]  green_i,
  input logic [rled_pkg::ColorW-1:0]  blue_i,
  input logic                         frame_start_i
);
  import rled_pkg::*;

  // one item in flight: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input still open after accepting a beat");

  // a new result only comes from a busy block
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while the block was idle");

  // a frame start never carries a colour
  a_frame_no_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && frame_start_i) |-> ((red_i == '0) && (green_i == '0) && (blue_i == '0)))
    else $error("frame start with non-zero colour");

  // stalled result stays offered
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

endmodule

bind rgb_led_effect_generator_top rled_checker u_rled_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .red_i         (result_o.red),
  .green_i       (result_o.green),
  .blue_i        (result_o.blue),
  .frame_start_i (result_o.frame_start)
);

`default_nettype wire

@@ verif/tb_rgb_led_effect_generator_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgb_led_effect_generator_top: directed and random beats.
// A scoreboard class predicts every colour and frame flag. Depends on rled_pkg,
// rled_in_if, rled_out_if and the top-level RTL.

module tb_rgb_led_effect_generator_top;
  import rled_pkg::*;

  localparam int unsigned LedMax     = 32;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned PhaseItems = 85;

  typedef struct packed {
    rled_op_e          cmd;
    logic [TimeW-1:0]  time_ms;
    logic [IdxW-1:0]   led_index;
    logic              strip_busy;
  } led_item_t;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              frame_start;
  } led_result_t;

  // Colour and frame-flag predictor with its own copy of registers and state
  class led_colour_scoreboard;
    rled_mode_e           mode;
    logic [CountW-1:0]    led_count;
    logic [IntervalW-1:0] interval;
    logic [TimeW-1:0]     last_step;
    logic [TimeW-1:0]     last_frame;
    logic [ColorW-1:0]    hue;
    logic [ColorW-1:0]    react;
    led_result_t          expected_colours[$];
    int                   errors;

    function new();
      mode       = MODE_RAINBOW;
      led_count  = 6'd32;
      interval   = 16'd20;
      last_step  = '0;
      last_frame = '0;
      hue        = '0;
      react      = '0;
      errors     = 0;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegMode:     mode = rled_mode_e'(data[1:0]);
        RegCount:    led_count = data[CountW-1:0];
        RegInterval: interval = data[IntervalW-1:0];
        default: ;
      endcase
    endfunction

    // 8-bit HSV to RGB, six sectors of 43 hue steps
    function void hsv_colour(int unsigned h, int unsigned s, int unsigned v,
                             output logic [ColorW-1:0] r, output logic [ColorW-1:0] g,
                             output logic [ColorW-1:0] b);
      int unsigned       sector, frac, lo, fall, rise;
      logic [ColorW-1:0] v8, lo8, fall8, rise8;
      sector = (h & 255) / 43;
      frac   = (((h & 255) - sector * 43) * 6) & 255;
      lo     = ((v * (255 - s)) >> 8) & 255;
      fall   = ((v * (255 - ((s * frac) >> 8))) >> 8) & 255;
      rise   = ((v * (255 - ((s * (255 - frac)) >> 8))) >> 8) & 255;
      v8     = ColorW'(v);
      lo8    = ColorW'(lo);
      fall8  = ColorW'(fall);
      rise8  = ColorW'(rise);
      case (sector)
        0: begin r = v8;    g = rise8; b = lo8;   end
        1: begin r = fall8; g = v8;    b = lo8;   end
        2: begin r = lo8;   g = v8;    b = rise8; end
        3: begin r = lo8;   g = fall8; b = v8;    end
        4: begin r = rise8; g = lo8;   b = v8;    end
        default: begin r = v8; g = lo8; b = fall8; end
      endcase
    endfunction

    // Accepted beat: update state and queue the colour it must produce
    function void note_item(led_item_t it);
      led_result_t      res;
      logic [TimeW-1:0] since;
      int unsigned      phase, val, h;
      res = '0;
      case (it.cmd)
        OP_TICK: begin
          if (it.time_ms != last_step) begin
            last_step = it.time_ms;
            if (it.time_ms % 10 == 0) hue = hue + 8'd1;
            if (it.time_ms % 5 == 0 && react != 0) react = react - 8'd1;
          end
          since = it.time_ms - last_frame;
          if (since >= {16'd0, interval}) begin
            last_frame      = it.time_ms;
            res.frame_start = !it.strip_busy;
          end
        end
        OP_KEY: react = ReactLoad;
        OP_PIXEL: begin
          if ({1'b0, it.led_index} < led_count) begin
            case (mode)
              MODE_STATIC:
                hsv_colour(128, 255, 60, res.red, res.green, res.blue);
              MODE_BREATH: begin
                phase = it.time_ms % 2000;
                val   = (phase < 1000) ? phase / 10 : (2000 - phase) / 10;
                hsv_colour(128, 255, val, res.red, res.green, res.blue);
              end
              MODE_REACT:
                hsv_colour(128, 255, react, res.red, res.green, res.blue);
              default: begin
                h = (hue + it.led_index * (256 / LedMax)) & 255;
                hsv_colour(h, 255, 60, res.red, res.green, res.blue);
              end
            endcase
          end
        end
        default: ;
      endcase
      expected_colours.push_back(res);
    endfunction

    function void compare_field(string name, logic [ColorW-1:0] want, logic [ColorW-1:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(led_result_t got);
      led_result_t want;
      if (expected_colours.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, got %0d/%0d/%0d fs %0d",
                 $time, got.red, got.green, got.blue, got.frame_start);
        errors++;
      end else begin
        want = expected_colours.pop_front();
        compare_field("red", want.red, got.red);
        compare_field("green", want.green, got.green);
        compare_field("blue", want.blue, got.blue);
        compare_field("frame_start", {7'd0, want.frame_start}, {7'd0, got.frame_start});
      end
    endfunction

    function int pending();
      return expected_colours.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_idx;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 calm;
  logic                 hold_req;
  logic [TimeW-1:0]     time_cursor;
  int unsigned          cycles;
  led_colour_scoreboard sb = new();

  rled_in_if  in_if ();
  rled_out_if out_if ();

  rgb_led_effect_generator_top #(
    .MAX_LEDS (LedMax)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_if),
    .result_o   (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock, 2 ns period
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure bursts, plus one long hold on request
  initial begin : result_sink
    int unsigned hold_left, idle_left;
    hold_left      = 0;
    idle_left      = 0;
    out_if.ready   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_if.ready = 1'b0;
        idle_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        idle_left    = $urandom_range(0, 2);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Result beats checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result({out_if.red, out_if.green, out_if.blue, out_if.frame_start});
  end

  // Offer one beat, starting and ending at a falling edge
  task automatic send_item(led_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_if.command    = it.cmd;
    in_if.time_ms    = it.time_ms;
    in_if.led_index  = it.led_index;
    in_if.strip_busy = it.strip_busy;
    in_if.valid      = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic send(rled_op_e op, logic [TimeW-1:0] t, logic [IdxW-1:0] idx, logic busy);
    led_item_t it;
    it.cmd        = op;
    it.time_ms    = t;
    it.led_index  = idx;
    it.strip_busy = busy;
    send_item(it);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    sb.apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Drain all results, then rewrite every register while the block is idle
  task automatic configure(rled_mode_e mode, logic [CountW-1:0] count,
                           logic [IntervalW-1:0] interval);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
    write_reg(RegMode, {14'd0, mode});
    write_reg(RegCount, {10'd0, count});
    write_reg(RegInterval, interval);
  endtask

  // Mostly a running clock with random content; some jumps and unknown opcodes
  task automatic send_random();
    led_item_t   it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 15) == 0) time_cursor = $urandom;
    if (sel < 45) begin
      it.cmd      = OP_TICK;
      time_cursor = time_cursor + $urandom_range(0, 6);
      it.time_ms  = time_cursor;
    end else if (sel < 85) begin
      it.cmd     = OP_PIXEL;
      it.time_ms = $urandom_range(0, 1) ? time_cursor : $urandom;
    end else if (sel < 92) begin
      it.cmd     = OP_KEY;
      it.time_ms = $urandom;
    end else begin
      it.cmd     = OP_NONE;
      it.time_ms = $urandom;
    end
    it.led_index  = IdxW'($urandom_range(0, 31));
    it.strip_busy = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic random_phase(rled_mode_e mode, logic [CountW-1:0] count,
                              logic [IntervalW-1:0] interval, logic long_hold);
    configure(mode, count, interval);
    if (long_hold) hold_req = 1'b1;
    repeat (PhaseItems) send_random();
  endtask

  // Main sequence
  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    time_cursor      = '0;
    in_if.valid      = 1'b0;
    in_if.command    = OP_TICK;
    in_if.time_ms    = '0;
    in_if.led_index  = '0;
    in_if.strip_busy = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: decay at zero level, hue steps, busy skip, frame start
    send(OP_TICK, 32'd5, 5'd0, 1'b0);
    send(OP_TICK, 32'd0, 5'd0, 1'b0);
    send(OP_TICK, 32'd20, 5'd0, 1'b1);
    send(OP_TICK, 32'd40, 5'd0, 1'b0);
    send(OP_PIXEL, 32'd0, 5'd0, 1'b0);
    send(OP_PIXEL, 32'hFFFF_FFFF, 5'd31, 1'b1);
    send(OP_NONE, 32'hFFFF_FFFF, 5'd31, 1'b1);
    send(OP_KEY, 32'd0, 5'd0, 1'b0);

    // Reactive, count above the LED maximum, zero interval
    configure(MODE_REACT, 6'd63, 16'd0);
    send(OP_PIXEL, 32'd0, 5'd31, 1'b0);
    send(OP_TICK, 32'd45, 5'd0, 1'b0);
    send(OP_TICK, 32'd45, 5'd0, 1'b1);
    send(OP_TICK, 32'hFFFF_FFFF, 5'd0, 1'b0);
    send(OP_PIXEL, 32'd7, 5'd17, 1'b0);

    // No LEDs lit
    configure(MODE_BREATH, 6'd0, 16'hFFFF);
    send(OP_PIXEL, 32'd999, 5'd0, 1'b0);

    // Breathing around the turning points, then a tick across the time wrap
    configure(MODE_BREATH, 6'd32, 16'hFFFF);
    send(OP_PIXEL, 32'd999, 5'd5, 1'b0);
    send(OP_PIXEL, 32'd1000, 5'd5, 1'b0);
    send(OP_PIXEL, 32'd1999, 5'd5, 1'b0);
    send(OP_PIXEL, 32'hFFFF_FFFF, 5'd5, 1'b0);
    send(OP_TICK, 32'd4, 5'd0, 1'b0);

    // Static with a single LED
    configure(MODE_STATIC, 6'd1, 16'd20);
    send(OP_PIXEL, 32'd0, 5'd0, 1'b0);
    send(OP_PIXEL, 32'd0, 5'd1, 1'b0);

    // Random phases across settings; the first one fills the block under a long hold
    time_cursor = 32'd100;
    random_phase(MODE_RAINBOW, 6'd32, 16'd20, 1'b1);
    random_phase(MODE_BREATH, 6'd63, 16'd0, 1'b0);
    random_phase(MODE_REACT, 6'd33, 16'hFFFF, 1'b0);
    random_phase(MODE_STATIC, 6'd1, 16'd1, 1'b0);
    random_phase(rled_mode_e'($urandom_range(0, 3)), CountW'($urandom_range(0, 63)),
                 IntervalW'($urandom_range(0, 50)), 1'b0);
    calm = 1'b1;
    random_phase(MODE_RAINBOW, CountW'($urandom_range(0, 63)),
                 IntervalW'($urandom_range(0, 30)), 1'b0);

    // Drain and let any stray beat show up
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
